// ----- rtl/tcp_connection_state_machine_top_defines.svh -----
// assertion macros shared by the tcp connection state machine rtl
// needs clk_i and rst_ni in the scope of the module that uses them
`ifndef TCP_CONNECTION_STATE_MACHINE_TOP_DEFINES_SVH
`define TCP_CONNECTION_STATE_MACHINE_TOP_DEFINES_SVH

// same-cycle implication
`define TCP_CSM_ASSERT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("tcp_csm assertion failed");

// next-cycle implication
`define TCP_CSM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("tcp_csm assertion failed");

`endif

// ----- rtl/tcp_csm_pkg.sv -----
// shared types and codes for the tcp connection state machine
// no dependencies
package tcp_csm_pkg;

  localparam int unsigned SeqW   = 32;
  localparam int unsigned StateW = 4;
  localparam int unsigned FlagsW = 6;
  localparam int unsigned KindW  = 2;
  localparam int unsigned EventW = 3;
  localparam int unsigned DropW  = 2;

  // operation codes
  localparam logic OP_SEGMENT = 1'b0;
  localparam logic OP_LOAD    = 1'b1;

  // flag bit positions
  localparam int unsigned FlagFinBit = 0;
  localparam int unsigned FlagSynBit = 1;
  localparam int unsigned FlagAckBit = 4;

  // connection states
  localparam logic [StateW-1:0] ST_CLOSED     = 4'd0;
  localparam logic [StateW-1:0] ST_LISTEN     = 4'd1;
  localparam logic [StateW-1:0] ST_SYN_RECV   = 4'd2;
  localparam logic [StateW-1:0] ST_SYN_SENT   = 4'd3;
  localparam logic [StateW-1:0] ST_ESTAB      = 4'd4;
  localparam logic [StateW-1:0] ST_CLOSE_WAIT = 4'd5;
  localparam logic [StateW-1:0] ST_LAST_ACK   = 4'd6;
  localparam logic [StateW-1:0] ST_FIN_WAIT_1 = 4'd7;
  localparam logic [StateW-1:0] ST_FIN_WAIT_2 = 4'd8;
  localparam logic [StateW-1:0] ST_CLOSING    = 4'd9;
  localparam logic [StateW-1:0] ST_TIME_WAIT  = 4'd10;

  // reply kinds
  localparam logic [KindW-1:0] RK_NONE   = 2'd0;
  localparam logic [KindW-1:0] RK_ACK    = 2'd1;
  localparam logic [KindW-1:0] RK_SYNACK = 2'd2;
  localparam logic [KindW-1:0] RK_RST    = 2'd3;

  // events
  localparam logic [EventW-1:0] EV_NONE      = 3'd0;
  localparam logic [EventW-1:0] EV_CONNECTED = 3'd1;
  localparam logic [EventW-1:0] EV_ACCEPTED  = 3'd2;
  localparam logic [EventW-1:0] EV_TIMEWAIT  = 3'd3;
  localparam logic [EventW-1:0] EV_CLOSED    = 3'd4;

  // drop status
  localparam logic [DropW-1:0] DROP_NONE       = 2'd0;
  localparam logic [DropW-1:0] DROP_BAD_ACK    = 2'd1;
  localparam logic [DropW-1:0] DROP_UNEXPECTED = 2'd2;

  typedef struct packed {
    logic              operation;
    logic [FlagsW-1:0] seg_flags;
    logic [SeqW-1:0]   seg_seq;
    logic [SeqW-1:0]   seg_ack;
    logic [SeqW-1:0]   fresh_iss;
    logic [StateW-1:0] load_state;
    logic [SeqW-1:0]   load_send_next;
    logic [SeqW-1:0]   load_recv_next;
  } item_t;

  typedef struct packed {
    logic [StateW-1:0] conn_state;
    logic [KindW-1:0]  reply_kind;
    logic [SeqW-1:0]   reply_seq;
    logic [SeqW-1:0]   reply_ack;
    logic              spawn_child;
    logic [EventW-1:0] conn_event;
    logic [DropW-1:0]  drop_status;
  } result_t;

  // handshake between the input register and the result register
  typedef struct packed {
    logic valid;
    logic take;
  } flow_t;

endpackage

// ----- rtl/tcp_csm_in_stage.sv -----
// input register of the tcp connection state machine
// depends on tcp_csm_pkg
module tcp_csm_in_stage
  import tcp_csm_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  item_t item_i,
  input  logic  take_i,
  output flow_t flow_o,
  output item_t item_o
);

  logic  valid_q, valid_d;
  item_t item_q;
  logic  accept;

  assign in_stall_o = valid_q && !take_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    valid_d = valid_q;
    if (accept) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= item_i;
    end
  end

  assign flow_o.valid = valid_q;
  assign flow_o.take  = valid_q && take_i;
  assign item_o       = item_q;

endmodule

// ----- rtl/tcp_csm_core.sv -----
// connection registers and per-beat next-state and reply logic
// depends on tcp_csm_pkg and the assertion macro header
`include "tcp_connection_state_machine_top_defines.svh"

module tcp_csm_core
  import tcp_csm_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    fire_i,
  input  item_t   item_i,
  output result_t res_o
);

  logic [StateW-1:0] state_q, state_d;
  logic [SeqW-1:0]   iss_q, iss_d;
  logic [SeqW-1:0]   snd_nxt_q, snd_nxt_d;
  logic [SeqW-1:0]   rcv_nxt_q, rcv_nxt_d;

  logic            has_fin, has_syn, has_ack, ack_ok;
  logic [SeqW-1:0] seq1;
  result_t         res;

  assign has_fin = item_i.seg_flags[FlagFinBit];
  assign has_syn = item_i.seg_flags[FlagSynBit];
  assign has_ack = item_i.seg_flags[FlagAckBit];
  assign seq1    = item_i.seg_seq + SeqW'(1);
  assign ack_ok  = item_i.seg_ack == (iss_q + SeqW'(1));

  always_comb begin
    state_d         = state_q;
    iss_d           = iss_q;
    snd_nxt_d       = snd_nxt_q;
    rcv_nxt_d       = rcv_nxt_q;
    res.reply_kind  = RK_NONE;
    res.spawn_child = 1'b0;
    res.conn_event  = EV_NONE;
    res.drop_status = DROP_NONE;
    if (item_i.operation == OP_LOAD) begin
      state_d   = (item_i.load_state > ST_TIME_WAIT) ? ST_CLOSED : item_i.load_state;
      iss_d     = item_i.fresh_iss;
      snd_nxt_d = item_i.load_send_next;
      rcv_nxt_d = item_i.load_recv_next;
    end else begin
      unique case (state_q)
        ST_CLOSED: begin
          res.reply_kind  = RK_RST;
          res.drop_status = DROP_UNEXPECTED;
        end
        ST_LISTEN: begin
          if (has_syn) begin
            res.reply_kind  = RK_SYNACK;
            res.spawn_child = 1'b1;
          end else begin
            res.reply_kind  = RK_RST;
            res.drop_status = DROP_UNEXPECTED;
          end
        end
        ST_SYN_SENT: begin
          if (has_syn && has_ack) begin
            if (ack_ok) begin
              rcv_nxt_d      = seq1;
              res.reply_kind = RK_ACK;
              state_d        = ST_ESTAB;
              res.conn_event = EV_CONNECTED;
            end else begin
              res.drop_status = DROP_BAD_ACK;
            end
          end else if (has_syn) begin
            rcv_nxt_d      = seq1;
            res.reply_kind = RK_ACK;
          end else begin
            res.drop_status = DROP_UNEXPECTED;
          end
        end
        ST_SYN_RECV: begin
          if (has_ack) begin
            if (ack_ok) begin
              state_d        = ST_ESTAB;
              res.conn_event = EV_ACCEPTED;
            end else begin
              res.drop_status = DROP_BAD_ACK;
            end
          end
        end
        ST_ESTAB: begin
          if (has_fin) begin
            rcv_nxt_d      = seq1;
            res.reply_kind = RK_ACK;
            state_d        = ST_CLOSE_WAIT;
          end
        end
        ST_FIN_WAIT_1: begin
          if (has_ack && has_fin) begin
            rcv_nxt_d      = seq1;
            res.reply_kind = RK_ACK;
            state_d        = ST_TIME_WAIT;
            res.conn_event = EV_TIMEWAIT;
          end else if (has_ack) begin
            state_d = ST_FIN_WAIT_2;
          end else if (has_fin) begin
            rcv_nxt_d      = seq1;
            res.reply_kind = RK_ACK;
            state_d        = ST_CLOSING;
          end
        end
        ST_FIN_WAIT_2: begin
          if (has_fin) begin
            rcv_nxt_d      = seq1;
            res.reply_kind = RK_ACK;
            state_d        = ST_TIME_WAIT;
            res.conn_event = EV_TIMEWAIT;
          end
        end
        ST_CLOSING: begin
          if (has_ack) begin
            state_d        = ST_TIME_WAIT;
            res.conn_event = EV_TIMEWAIT;
          end
        end
        ST_LAST_ACK: begin
          if (has_ack) begin
            state_d        = ST_CLOSED;
            res.conn_event = EV_CLOSED;
          end
        end
        default: begin
        end
      endcase
    end

    res.conn_state = state_d;
    case (res.reply_kind)
      RK_ACK: begin
        res.reply_seq = snd_nxt_q;
        res.reply_ack = rcv_nxt_d;
      end
      RK_SYNACK: begin
        res.reply_seq = item_i.fresh_iss;
        res.reply_ack = seq1;
      end
      RK_RST: begin
        res.reply_seq = item_i.seg_ack;
        res.reply_ack = seq1;
      end
      default: begin
        res.reply_seq = '0;
        res.reply_ack = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLOSED;
      iss_q     <= '0;
      snd_nxt_q <= '0;
      rcv_nxt_q <= '0;
    end else if (fire_i) begin
      state_q   <= state_d;
      iss_q     <= iss_d;
      snd_nxt_q <= snd_nxt_d;
      rcv_nxt_q <= rcv_nxt_d;
    end
  end

  assign res_o = res;

  `TCP_CSM_ASSERT(a_no_reply_zero, res.reply_kind == RK_NONE, res.reply_seq == '0 && res.reply_ack == '0)
  `TCP_CSM_ASSERT(a_spawn_in_listen, res.spawn_child, state_q == ST_LISTEN && state_d == ST_LISTEN)
  `TCP_CSM_ASSERT(a_drop_keeps_state, fire_i && res.drop_status != DROP_NONE, state_d == state_q)
  `TCP_CSM_ASSERT_NEXT(a_idle_holds, !fire_i, $stable(state_q) && $stable(rcv_nxt_q))

endmodule

// ----- rtl/tcp_csm_out_stage.sv -----
// result register of the tcp connection state machine
// depends on tcp_csm_pkg
module tcp_csm_out_stage
  import tcp_csm_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    fire_i,
  input  result_t res_i,
  output logic    ready_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t res_o
);

  logic    valid_q, valid_d;
  result_t res_q;

  assign ready_o = !valid_q || !out_stall_i;

  always_comb begin
    valid_d = valid_q;
    if (ready_o) begin
      valid_d = fire_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign res_o       = res_q;

endmodule

// ----- rtl/tcp_connection_state_machine_top.sv -----
// One TCP connection's state machine. Each input beat is either a received segment or a load
// of the connection registers from software; each beat yields exactly one result beat with the
// new state, the control segment to send, an event and a drop status. A beat is registered in
// the input register on acceptance and its result is registered in the result register once
// the result register is ready to take it, which an output stall can delay. While the
// result is stalled the input register holds its beat, so up to two beats wait in the block.
// One beat is taken every cycle while the result is not stalled; the rate is set by the
// state, ISS, send-next and receive-next registers, which feed their own next-state logic.
// Depends on tcp_csm_pkg, tcp_csm_in_stage, tcp_csm_core and tcp_csm_out_stage.
module tcp_connection_state_machine_top
  import tcp_csm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              operation_i,
  input  logic [FlagsW-1:0] seg_flags_i,
  input  logic [SeqW-1:0]   seg_seq_i,
  input  logic [SeqW-1:0]   seg_ack_i,
  input  logic [SeqW-1:0]   fresh_iss_i,
  input  logic [StateW-1:0] load_state_i,
  input  logic [SeqW-1:0]   load_send_next_i,
  input  logic [SeqW-1:0]   load_recv_next_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [StateW-1:0] conn_state_o,
  output logic [KindW-1:0]  reply_kind_o,
  output logic [SeqW-1:0]   reply_seq_o,
  output logic [SeqW-1:0]   reply_ack_o,
  output logic              spawn_child_o,
  output logic [EventW-1:0] conn_event_o,
  output logic [DropW-1:0]  drop_status_o
);

  item_t   in_item, cur_item;
  flow_t   flow;
  logic    out_ready;
  result_t core_res, out_res;

  assign in_item.operation      = operation_i;
  assign in_item.seg_flags      = seg_flags_i;
  assign in_item.seg_seq        = seg_seq_i;
  assign in_item.seg_ack        = seg_ack_i;
  assign in_item.fresh_iss      = fresh_iss_i;
  assign in_item.load_state     = load_state_i;
  assign in_item.load_send_next = load_send_next_i;
  assign in_item.load_recv_next = load_recv_next_i;

  tcp_csm_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .item_i     (in_item),
    .take_i     (out_ready),
    .flow_o     (flow),
    .item_o     (cur_item)
  );

  tcp_csm_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (flow.take),
    .item_i (cur_item),
    .res_o  (core_res)
  );

  tcp_csm_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (flow.take),
    .res_i       (core_res),
    .ready_o     (out_ready),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (out_res)
  );

  assign conn_state_o  = out_res.conn_state;
  assign reply_kind_o  = out_res.reply_kind;
  assign reply_seq_o   = out_res.reply_seq;
  assign reply_ack_o   = out_res.reply_ack;
  assign spawn_child_o = out_res.spawn_child;
  assign conn_event_o  = out_res.conn_event;
  assign drop_status_o = out_res.drop_status;

endmodule
